// ===== src/sbt_pkg.sv =====
`default_nettype none
package sbt_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int LINE_W    = 20;
    localparam int COL_W     = 16;
    localparam int KIND_W    = 7;
    localparam int ACT_W     = 3;
    localparam int EIDX_W    = 10;
    localparam int STAT_W    = 2;
    localparam int TOTAL_W   = 11;
    localparam logic [LINE_W-1:0] LINE_SAT = 20'hFFFFF;

    localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PARTNER = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_ADD     = 3'd5;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd6;
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic [KIND_W-1:0] kind;
        logic              open;
    } bkt_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_RD_I,
        OP_INC_I,
        OP_SET_D_CNT,
        OP_SH_RD,
        OP_SH_WR,
        OP_INS_WR,
        OP_PREV,
        OP_RES_RD,
        OP_RES_PREV,
        OP_RES_NF,
        OP_RES_FULL,
        OP_RES_OK,
        OP_RD_EIDX,
        OP_PT_INIT,
        OP_DEC_RD,
        OP_PT_SAME,
        OP_PT_OPP,
        OP_PT_SKIP,
        OP_SET_D,
        OP_SET_CNT_D,
        OP_CP_WR,
        OP_AD_WR
    } dp_op_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             full;
        logic             eidx_ok;
        logic             i_lt_cnt;
        logic             i_eq_d;
        logic             i_zero;
        logic             before_ins;
        logic             line_lt_ln;
        logic             line_eq_ln;
        logic             line_lt_end;
        logic             col_gt;
        logic             col_eq;
        logic             prev_hit;
        logic             kind_eq;
        logic             same_dir;
        logic             depth_one;
        logic             popen;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== src/sbt_if.sv =====
`default_nettype none
interface sbt_req_if;
    logic                          valid;
    logic                          ready;
    logic [sbt_pkg::ACT_W-1:0]     action;
    logic [sbt_pkg::LINE_W-1:0]    position_line;
    logic [sbt_pkg::COL_W-1:0]     position_col;
    logic [sbt_pkg::KIND_W-1:0]    paren_kind;
    logic                          is_open;
    logic [sbt_pkg::EIDX_W-1:0]    entry_index;
    logic [sbt_pkg::LINE_W-1:0]    line_count;

    modport source (output valid, action, position_line, position_col, paren_kind,
                    is_open, entry_index, line_count, input ready);
    modport sink   (input valid, action, position_line, position_col, paren_kind,
                    is_open, entry_index, line_count, output ready);
endinterface

interface sbt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sbt_pkg::STAT_W-1:0]    status;
    logic [sbt_pkg::EIDX_W-1:0]    result_index;
    logic [sbt_pkg::LINE_W-1:0]    entry_line;
    logic [sbt_pkg::COL_W-1:0]     entry_col;
    logic [sbt_pkg::KIND_W-1:0]    entry_kind;
    logic                          entry_open;
    logic [sbt_pkg::TOTAL_W-1:0]   total_entries;

    modport source (output valid, status, result_index, entry_line, entry_col,
                    entry_kind, entry_open, total_entries, input ready);
    modport sink   (input valid, status, result_index, entry_line, entry_col,
                    entry_kind, entry_open, total_entries, output ready);
endinterface
`default_nettype wire

// ===== src/sbt_ctrl.sv =====
`default_nettype none
module sbt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire sbt_pkg::dp_status_t st,
    output sbt_pkg::dp_op_t          op
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_INS_RD, S_INS_CHK, S_SH, S_SH_WR,
        S_LK_RD, S_LK_CHK, S_LK_END, S_PT_HEAD, S_PT_STEP, S_PT_CHK,
        S_RE_OUT, S_FL_RD, S_FL_CHK, S_RM_RD, S_RM_CHK, S_CP, S_CP_WR,
        S_AD_RD, S_AD_WR, S_OUT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        op         = sbt_pkg::OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = sbt_pkg::OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.act)
                    sbt_pkg::ACT_INSERT:
                    begin
                        if (st.full)
                        begin
                            op         = sbt_pkg::OP_RES_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                    sbt_pkg::ACT_LOOKUP:
                    begin
                        state_next = S_LK_RD;
                    end
                    sbt_pkg::ACT_PARTNER, sbt_pkg::ACT_READ:
                    begin
                        if (!st.eidx_ok)
                        begin
                            op         = sbt_pkg::OP_RES_NF;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            op         = sbt_pkg::OP_RD_EIDX;
                            state_next = (st.act == sbt_pkg::ACT_READ) ? S_RE_OUT : S_PT_HEAD;
                        end
                    end
                    sbt_pkg::ACT_CLEAR, sbt_pkg::ACT_ADD, sbt_pkg::ACT_REMOVE:
                    begin
                        state_next = S_FL_RD;
                    end
                    default:
                    begin
                        op         = sbt_pkg::OP_RES_NF;
                        state_next = S_OUT;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (st.i_lt_cnt)
                begin
                    op         = sbt_pkg::OP_RD_I;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    op         = sbt_pkg::OP_SET_D_CNT;
                    state_next = S_SH;
                end
            end
            S_INS_CHK:
            begin
                if (st.before_ins)
                begin
                    op         = sbt_pkg::OP_INC_I;
                    state_next = S_INS_RD;
                end
                else
                begin
                    op         = sbt_pkg::OP_SET_D_CNT;
                    state_next = S_SH;
                end
            end
            S_SH:
            begin
                if (st.i_eq_d)
                begin
                    op         = sbt_pkg::OP_INS_WR;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = sbt_pkg::OP_SH_RD;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                op         = sbt_pkg::OP_SH_WR;
                state_next = S_SH;
            end
            S_LK_RD:
            begin
                if (st.i_lt_cnt)
                begin
                    op         = sbt_pkg::OP_RD_I;
                    state_next = S_LK_CHK;
                end
                else
                begin
                    state_next = S_LK_END;
                end
            end
            S_LK_CHK:
            begin
                if (st.line_lt_ln)
                begin
                    op         = sbt_pkg::OP_INC_I;
                    state_next = S_LK_RD;
                end
                else if (st.line_eq_ln && st.col_eq)
                begin
                    op         = sbt_pkg::OP_RES_RD;
                    state_next = S_OUT;
                end
                else if (st.line_eq_ln && !st.col_gt)
                begin
                    op         = sbt_pkg::OP_PREV;
                    state_next = S_LK_RD;
                end
                else
                begin
                    state_next = S_LK_END;
                end
            end
            S_LK_END:
            begin
                op         = st.prev_hit ? sbt_pkg::OP_RES_PREV : sbt_pkg::OP_RES_NF;
                state_next = S_OUT;
            end
            S_PT_HEAD:
            begin
                op         = sbt_pkg::OP_PT_INIT;
                state_next = S_PT_STEP;
            end
            S_PT_STEP:
            begin
                if (st.popen ? !st.i_lt_cnt : st.i_zero)
                begin
                    op         = sbt_pkg::OP_RES_NF;
                    state_next = S_OUT;
                end
                else
                begin
                    op         = st.popen ? sbt_pkg::OP_RD_I : sbt_pkg::OP_DEC_RD;
                    state_next = S_PT_CHK;
                end
            end
            S_PT_CHK:
            begin
                state_next = S_PT_STEP;
                if (!st.kind_eq)
                begin
                    op = sbt_pkg::OP_PT_SKIP;
                end
                else if (st.same_dir)
                begin
                    op = sbt_pkg::OP_PT_SAME;
                end
                else if (st.depth_one)
                begin
                    op         = sbt_pkg::OP_RES_RD;
                    state_next = S_OUT;
                end
                else
                begin
                    op = sbt_pkg::OP_PT_OPP;
                end
            end
            S_RE_OUT:
            begin
                op         = sbt_pkg::OP_RES_RD;
                state_next = S_OUT;
            end
            S_FL_RD:
            begin
                if (st.i_lt_cnt)
                begin
                    op         = sbt_pkg::OP_RD_I;
                    state_next = S_FL_CHK;
                end
                else
                begin
                    op         = sbt_pkg::OP_SET_D;
                    state_next = (st.act == sbt_pkg::ACT_ADD) ? S_AD_RD : S_RM_RD;
                end
            end
            S_FL_CHK:
            begin
                if (st.line_lt_ln)
                begin
                    op         = sbt_pkg::OP_INC_I;
                    state_next = S_FL_RD;
                end
                else
                begin
                    op         = sbt_pkg::OP_SET_D;
                    state_next = (st.act == sbt_pkg::ACT_ADD) ? S_AD_RD : S_RM_RD;
                end
            end
            S_RM_RD:
            begin
                if (st.i_lt_cnt)
                begin
                    op         = sbt_pkg::OP_RD_I;
                    state_next = S_RM_CHK;
                end
                else
                begin
                    state_next = S_CP;
                end
            end
            S_RM_CHK:
            begin
                if (st.line_lt_end)
                begin
                    op         = sbt_pkg::OP_INC_I;
                    state_next = S_RM_RD;
                end
                else
                begin
                    state_next = S_CP;
                end
            end
            S_CP:
            begin
                if (st.i_lt_cnt)
                begin
                    op         = sbt_pkg::OP_RD_I;
                    state_next = S_CP_WR;
                end
                else
                begin
                    op         = sbt_pkg::OP_SET_CNT_D;
                    state_next = S_OUT;
                end
            end
            S_CP_WR:
            begin
                op         = sbt_pkg::OP_CP_WR;
                state_next = S_CP;
            end
            S_AD_RD:
            begin
                if (st.i_lt_cnt)
                begin
                    op         = sbt_pkg::OP_RD_I;
                    state_next = S_AD_WR;
                end
                else
                begin
                    op         = sbt_pkg::OP_RES_OK;
                    state_next = S_OUT;
                end
            end
            S_AD_WR:
            begin
                op         = sbt_pkg::OP_AD_WR;
                state_next = S_AD_RD;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted request did not start dispatch");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("response dropped while stalled");
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request taken while response pending");

endmodule
`default_nettype wire

// ===== src/sbt_dp.sv =====
`default_nettype none
module sbt_dp #(
    parameter int DEPTH = sbt_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sbt_pkg::dp_op_t               op,
    output sbt_pkg::dp_status_t                st,
    input  wire logic [sbt_pkg::ACT_W-1:0]     action,
    input  wire logic [sbt_pkg::LINE_W-1:0]    position_line,
    input  wire logic [sbt_pkg::COL_W-1:0]     position_col,
    input  wire logic [sbt_pkg::KIND_W-1:0]    paren_kind,
    input  wire logic                          is_open,
    input  wire logic [sbt_pkg::EIDX_W-1:0]    entry_index,
    input  wire logic [sbt_pkg::LINE_W-1:0]    line_count,
    output logic [sbt_pkg::STAT_W-1:0]         status,
    output logic [sbt_pkg::EIDX_W-1:0]         result_index,
    output logic [sbt_pkg::LINE_W-1:0]         entry_line,
    output logic [sbt_pkg::COL_W-1:0]          entry_col,
    output logic [sbt_pkg::KIND_W-1:0]         entry_kind,
    output logic                               entry_open,
    output logic [sbt_pkg::TOTAL_W-1:0]        total_entries
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = sbt_pkg::LINE_W;

    sbt_pkg::bkt_t mem [DEPTH];
    sbt_pkg::bkt_t rd_reg;

    logic                         mem_we;
    logic [AW-1:0]                mem_wa;
    logic [AW-1:0]                mem_ra;
    sbt_pkg::bkt_t                mem_wd;

    logic [sbt_pkg::ACT_W-1:0]    act_reg, act_next;
    logic [LW-1:0]                ln_reg, ln_next;
    logic [sbt_pkg::COL_W-1:0]    col_reg, col_next;
    logic [sbt_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic                         open_reg, open_next;
    logic [sbt_pkg::EIDX_W-1:0]   eidx_reg, eidx_next;
    logic [LW-1:0]                cnt_reg, cnt_next;
    logic [CW-1:0]                i_reg, i_next;
    logic [CW-1:0]                d_reg, d_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW:0]                  depth_reg, depth_next;
    logic [sbt_pkg::KIND_W-1:0]   pkind_reg, pkind_next;
    logic                         popen_reg, popen_next;
    sbt_pkg::bkt_t                prev_reg, prev_next;
    logic                         have_prev_reg, have_prev_next;
    logic [sbt_pkg::STAT_W-1:0]   rs_reg, rs_next;
    logic [CW-1:0]                ri_reg, ri_next;
    sbt_pkg::bkt_t                re_reg, re_next;

    logic [CW-1:0]                i_m1;
    logic [LW:0]                  end_line;
    logic [LW-1:0]                sub_lines;
    logic [LW:0]                  add_sum;
    sbt_pkg::bkt_t                new_ent;
    sbt_pkg::bkt_t                shifted;

    assign i_m1      = i_reg - CW'(1);
    assign end_line  = (act_reg == sbt_pkg::ACT_CLEAR) ? ({1'b0, ln_reg} + (LW+1)'(1))
                                                       : ({1'b0, ln_reg} + {1'b0, cnt_reg});
    assign sub_lines = (act_reg == sbt_pkg::ACT_CLEAR) ? '0 : cnt_reg;
    assign add_sum   = {1'b0, rd_reg.line} + {1'b0, cnt_reg};
    assign new_ent   = '{line: ln_reg, col: col_reg, kind: kind_reg, open: open_reg};

    always_comb
    begin
        st.act         = act_reg;
        st.full        = (count_reg == CW'(DEPTH));
        st.eidx_ok     = (32'(eidx_reg) < 32'(count_reg));
        st.i_lt_cnt    = (i_reg < count_reg);
        st.i_eq_d      = (i_reg == d_reg);
        st.i_zero      = (i_reg == '0);
        st.before_ins  = (rd_reg.line < ln_reg) ||
                         ((rd_reg.line == ln_reg) && (rd_reg.col < col_reg));
        st.line_lt_ln  = (rd_reg.line < ln_reg);
        st.line_eq_ln  = (rd_reg.line == ln_reg);
        st.line_lt_end = ({1'b0, rd_reg.line} < end_line);
        st.col_gt      = (rd_reg.col > col_reg);
        st.col_eq      = (rd_reg.col == col_reg);
        st.prev_hit    = have_prev_reg &&
                         (({1'b0, prev_reg.col} + 17'd1) == {1'b0, col_reg});
        st.kind_eq     = (rd_reg.kind == pkind_reg);
        st.same_dir    = (rd_reg.open == popen_reg);
        st.depth_one   = (depth_reg == (CW+1)'(1));
        st.popen       = popen_reg;
    end

    always_comb
    begin
        act_next       = act_reg;
        ln_next        = ln_reg;
        col_next       = col_reg;
        kind_next      = kind_reg;
        open_next      = open_reg;
        eidx_next      = eidx_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        d_next         = d_reg;
        count_next     = count_reg;
        depth_next     = depth_reg;
        pkind_next     = pkind_reg;
        popen_next     = popen_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        rs_next        = rs_reg;
        ri_next        = ri_reg;
        re_next        = re_reg;
        mem_we         = 1'b0;
        mem_wa         = i_reg[AW-1:0];
        mem_ra         = i_reg[AW-1:0];
        mem_wd         = rd_reg;
        shifted        = rd_reg;
        case (op)
            sbt_pkg::OP_LOAD:
            begin
                act_next       = action;
                ln_next        = position_line;
                col_next       = position_col;
                kind_next      = paren_kind;
                open_next      = is_open;
                eidx_next      = entry_index;
                cnt_next       = line_count;
                i_next         = '0;
                d_next         = '0;
                have_prev_next = 1'b0;
            end
            sbt_pkg::OP_RD_I:
            begin
                mem_ra = i_reg[AW-1:0];
            end
            sbt_pkg::OP_INC_I:
            begin
                i_next = i_reg + CW'(1);
            end
            sbt_pkg::OP_SET_D_CNT:
            begin
                d_next = i_reg;
                i_next = count_reg;
            end
            sbt_pkg::OP_SH_RD:
            begin
                mem_ra = i_m1[AW-1:0];
            end
            sbt_pkg::OP_SH_WR:
            begin
                mem_we = 1'b1;
                mem_wa = i_reg[AW-1:0];
                mem_wd = rd_reg;
                i_next = i_m1;
            end
            sbt_pkg::OP_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_wa     = d_reg[AW-1:0];
                mem_wd     = new_ent;
                count_next = count_reg + CW'(1);
                rs_next    = sbt_pkg::ST_OK;
                ri_next    = d_reg;
                re_next    = new_ent;
            end
            sbt_pkg::OP_PREV:
            begin
                prev_next      = rd_reg;
                have_prev_next = 1'b1;
                i_next         = i_reg + CW'(1);
            end
            sbt_pkg::OP_RES_RD:
            begin
                rs_next = sbt_pkg::ST_OK;
                ri_next = i_reg;
                re_next = rd_reg;
            end
            sbt_pkg::OP_RES_PREV:
            begin
                rs_next = sbt_pkg::ST_OK;
                ri_next = i_m1;
                re_next = prev_reg;
            end
            sbt_pkg::OP_RES_NF:
            begin
                rs_next = sbt_pkg::ST_NOTFOUND;
                ri_next = '0;
                re_next = '0;
            end
            sbt_pkg::OP_RES_FULL:
            begin
                rs_next = sbt_pkg::ST_FULL;
                ri_next = '0;
                re_next = '0;
            end
            sbt_pkg::OP_RES_OK:
            begin
                rs_next = sbt_pkg::ST_OK;
                ri_next = '0;
                re_next = '0;
            end
            sbt_pkg::OP_RD_EIDX:
            begin
                mem_ra = AW'(eidx_reg);
                i_next = CW'(eidx_reg);
            end
            sbt_pkg::OP_PT_INIT:
            begin
                pkind_next = rd_reg.kind;
                popen_next = rd_reg.open;
                depth_next = (CW+1)'(1);
                i_next     = rd_reg.open ? (i_reg + CW'(1)) : i_reg;
            end
            sbt_pkg::OP_DEC_RD:
            begin
                mem_ra = i_m1[AW-1:0];
                i_next = i_m1;
            end
            sbt_pkg::OP_PT_SAME:
            begin
                depth_next = depth_reg + (CW+1)'(1);
                i_next     = popen_reg ? (i_reg + CW'(1)) : i_reg;
            end
            sbt_pkg::OP_PT_OPP:
            begin
                depth_next = depth_reg - (CW+1)'(1);
                i_next     = popen_reg ? (i_reg + CW'(1)) : i_reg;
            end
            sbt_pkg::OP_PT_SKIP:
            begin
                i_next = popen_reg ? (i_reg + CW'(1)) : i_reg;
            end
            sbt_pkg::OP_SET_D:
            begin
                d_next = i_reg;
            end
            sbt_pkg::OP_SET_CNT_D:
            begin
                count_next = d_reg;
                rs_next    = sbt_pkg::ST_OK;
                ri_next    = '0;
                re_next    = '0;
            end
            sbt_pkg::OP_CP_WR:
            begin
                shifted.line = rd_reg.line - sub_lines;
                mem_we       = 1'b1;
                mem_wa       = d_reg[AW-1:0];
                mem_wd       = shifted;
                d_next       = d_reg + CW'(1);
                i_next       = i_reg + CW'(1);
            end
            sbt_pkg::OP_AD_WR:
            begin
                shifted.line = add_sum[LW] ? sbt_pkg::LINE_SAT : add_sum[LW-1:0];
                mem_we       = 1'b1;
                mem_wa       = i_reg[AW-1:0];
                mem_wd       = shifted;
                i_next       = i_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        ln_reg        <= ln_next;
        col_reg       <= col_next;
        kind_reg      <= kind_next;
        open_reg      <= open_next;
        eidx_reg      <= eidx_next;
        cnt_reg       <= cnt_next;
        i_reg         <= i_next;
        d_reg         <= d_next;
        depth_reg     <= depth_next;
        pkind_reg     <= pkind_next;
        popen_reg     <= popen_next;
        prev_reg      <= prev_next;
        have_prev_reg <= have_prev_next;
        rs_reg        <= rs_next;
        ri_reg        <= ri_next;
        re_reg        <= re_next;
    end

    assign status        = rs_reg;
    assign result_index  = sbt_pkg::EIDX_W'(ri_reg);
    assign entry_line    = re_reg.line;
    assign entry_col     = re_reg.col;
    assign entry_kind    = re_reg.kind;
    assign entry_open    = re_reg.open;
    assign total_entries = sbt_pkg::TOTAL_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        (op == sbt_pkg::OP_INS_WR) |-> (count_reg < CW'(DEPTH)))
        else $error("insert into full table");
    a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
        (op == sbt_pkg::OP_CP_WR) |-> (d_reg <= i_reg))
        else $error("compaction destination past source");
    a_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (op == sbt_pkg::OP_SET_CNT_D) |=> (count_reg <= $past(count_reg)))
        else $error("removal grew the table");

endmodule
`default_nettype wire

// ===== src/sorted_bracket_table.sv =====
`default_nettype none
// channel  role    moves
// req      sink    action, position_line, position_col, paren_kind, is_open,
//                  entry_index, line_count
// rsp      source  status, result_index, entry_line, entry_col, entry_kind,
//                  entry_open, total_entries
//
// one request at a time over a table memory with one read and one write port, registered read
// insert: scans the entries before the slot, then shifts each later entry up
// lookup, partner: walk the table entry by entry; read entry: one indexed read
// clear, lines removed/inserted: scan to the line, then move or adjust entries
// reset empties the table at once; the response holds until taken
module sorted_bracket_table #(
    parameter int DEPTH = sbt_pkg::DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sbt_req_if.sink    req,
    sbt_rsp_if.source  rsp
);

    sbt_pkg::dp_op_t     op;
    sbt_pkg::dp_status_t st;

    sbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .st        (st),
        .op        (op)
    );

    sbt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .st            (st),
        .action        (req.action),
        .position_line (req.position_line),
        .position_col  (req.position_col),
        .paren_kind    (req.paren_kind),
        .is_open       (req.is_open),
        .entry_index   (req.entry_index),
        .line_count    (req.line_count),
        .status        (rsp.status),
        .result_index  (rsp.result_index),
        .entry_line    (rsp.entry_line),
        .entry_col     (rsp.entry_col),
        .entry_kind    (rsp.entry_kind),
        .entry_open    (rsp.entry_open),
        .total_entries (rsp.total_entries)
    );

endmodule
`default_nettype wire

// ===== verif/tb_sorted_bracket_table.sv =====
`default_nettype none
module tb_sorted_bracket_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH = sbt_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 40000000;

    typedef struct {
        logic [sbt_pkg::STAT_W-1:0]  status;
        logic [sbt_pkg::EIDX_W-1:0]  idx;
        logic [sbt_pkg::LINE_W-1:0]  line;
        logic [sbt_pkg::COL_W-1:0]   col;
        logic [sbt_pkg::KIND_W-1:0]  kind;
        logic                        open;
        logic [sbt_pkg::TOTAL_W-1:0] total;
    } answer_t;

    logic clk;
    logic rst_n;
    int   cycle_cnt;
    int   err_cnt;
    bit   idle_on;
    bit   hold_rsp;

    sbt_req_if req ();
    sbt_rsp_if rsp ();

    sorted_bracket_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    sbt_pkg::bkt_t table_mdl [TBL_DEPTH];
    int            table_cnt;
    answer_t       answer_q [$];

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic answer_t make_answer(logic [sbt_pkg::STAT_W-1:0] st, int idx,
                                            bit with_entry);
        answer_t a;
        a = '{default: '0};
        a.status = st;
        if (with_entry && idx < table_cnt)
        begin
            a.idx  = idx[sbt_pkg::EIDX_W-1:0];
            a.line = table_mdl[idx].line;
            a.col  = table_mdl[idx].col;
            a.kind = table_mdl[idx].kind;
            a.open = table_mdl[idx].open;
        end
        a.total = table_cnt[sbt_pkg::TOTAL_W-1:0];
        return a;
    endfunction

    function automatic int first_at_line(int ln);
        int i;
        i = 0;
        while (i < table_cnt && int'(table_mdl[i].line) < ln)
            i++;
        return i;
    endfunction

    function automatic answer_t table_predict(logic [sbt_pkg::ACT_W-1:0] act, int ln, int col,
                                              int kind, bit opn, int eidx, int cnt);
        int i;
        int j;
        int first;
        int depth;
        int endl;
        int v;
        int k;
        ln   = ln & ((1 << sbt_pkg::LINE_W) - 1);
        col  = col & ((1 << sbt_pkg::COL_W) - 1);
        kind = kind & ((1 << sbt_pkg::KIND_W) - 1);
        eidx = eidx & ((1 << sbt_pkg::EIDX_W) - 1);
        cnt  = cnt & ((1 << sbt_pkg::LINE_W) - 1);
        case (act)
            sbt_pkg::ACT_INSERT:
            begin
                if (table_cnt >= TBL_DEPTH)
                    return make_answer(sbt_pkg::ST_FULL, 0, 0);
                i = 0;
                while (i < table_cnt && (int'(table_mdl[i].line) < ln ||
                       (int'(table_mdl[i].line) == ln && int'(table_mdl[i].col) < col)))
                    i++;
                for (j = table_cnt; j > i; j--)
                    table_mdl[j] = table_mdl[j-1];
                table_mdl[i].line = ln[sbt_pkg::LINE_W-1:0];
                table_mdl[i].col  = col[sbt_pkg::COL_W-1:0];
                table_mdl[i].kind = kind[sbt_pkg::KIND_W-1:0];
                table_mdl[i].open = opn;
                table_cnt++;
                return make_answer(sbt_pkg::ST_OK, i, 1);
            end
            sbt_pkg::ACT_LOOKUP:
            begin
                first = first_at_line(ln);
                i = first;
                while (i < table_cnt && int'(table_mdl[i].line) == ln)
                begin
                    if (int'(table_mdl[i].col) > col)
                        break;
                    if (int'(table_mdl[i].col) == col)
                        return make_answer(sbt_pkg::ST_OK, i, 1);
                    i++;
                end
                if (i > first && int'(table_mdl[i-1].col) + 1 == col)
                    return make_answer(sbt_pkg::ST_OK, i - 1, 1);
                return make_answer(sbt_pkg::ST_NOTFOUND, 0, 0);
            end
            sbt_pkg::ACT_PARTNER:
            begin
                if (eidx >= table_cnt)
                    return make_answer(sbt_pkg::ST_NOTFOUND, 0, 0);
                k = table_mdl[eidx].kind;
                depth = 1;
                if (table_mdl[eidx].open)
                begin
                    for (i = eidx + 1; i < table_cnt; i++)
                    begin
                        if (int'(table_mdl[i].kind) != k)
                            continue;
                        if (table_mdl[i].open)
                            depth++;
                        else
                        begin
                            depth--;
                            if (depth == 0)
                                return make_answer(sbt_pkg::ST_OK, i, 1);
                        end
                    end
                end
                else
                begin
                    for (i = eidx - 1; i >= 0; i--)
                    begin
                        if (int'(table_mdl[i].kind) != k)
                            continue;
                        if (!table_mdl[i].open)
                            depth++;
                        else
                        begin
                            depth--;
                            if (depth == 0)
                                return make_answer(sbt_pkg::ST_OK, i, 1);
                        end
                    end
                end
                return make_answer(sbt_pkg::ST_NOTFOUND, 0, 0);
            end
            sbt_pkg::ACT_READ:
            begin
                if (eidx >= table_cnt)
                    return make_answer(sbt_pkg::ST_NOTFOUND, 0, 0);
                return make_answer(sbt_pkg::ST_OK, eidx, 1);
            end
            sbt_pkg::ACT_CLEAR:
            begin
                first = first_at_line(ln);
                j = first;
                while (j < table_cnt && int'(table_mdl[j].line) == ln)
                    j++;
                for (i = j; i < table_cnt; i++)
                    table_mdl[first + i - j] = table_mdl[i];
                table_cnt -= j - first;
                return make_answer(sbt_pkg::ST_OK, 0, 0);
            end
            sbt_pkg::ACT_ADD:
            begin
                for (i = first_at_line(ln); i < table_cnt; i++)
                begin
                    v = int'(table_mdl[i].line) + cnt;
                    table_mdl[i].line = (v > int'(sbt_pkg::LINE_SAT)) ? sbt_pkg::LINE_SAT
                                                                       : v[sbt_pkg::LINE_W-1:0];
                end
                return make_answer(sbt_pkg::ST_OK, 0, 0);
            end
            sbt_pkg::ACT_REMOVE:
            begin
                endl = ln + cnt;
                first = first_at_line(ln);
                j = first;
                while (j < table_cnt && int'(table_mdl[j].line) < endl)
                    j++;
                for (i = j; i < table_cnt; i++)
                    table_mdl[first + i - j] = table_mdl[i];
                table_cnt -= j - first;
                for (i = first; i < table_cnt; i++)
                    table_mdl[i].line = table_mdl[i].line - cnt[sbt_pkg::LINE_W-1:0];
                return make_answer(sbt_pkg::ST_OK, 0, 0);
            end
            default:
                return make_answer(sbt_pkg::ST_NOTFOUND, 0, 0);
        endcase
    endfunction

    task automatic send_request(logic [sbt_pkg::ACT_W-1:0] act, int ln, int col, int kind,
                                bit opn, int eidx, int cnt);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.action        <= act;
        req.position_line <= ln[sbt_pkg::LINE_W-1:0];
        req.position_col  <= col[sbt_pkg::COL_W-1:0];
        req.paren_kind    <= kind[sbt_pkg::KIND_W-1:0];
        req.is_open       <= opn;
        req.entry_index   <= eidx[sbt_pkg::EIDX_W-1:0];
        req.line_count    <= cnt[sbt_pkg::LINE_W-1:0];
        do
            @(posedge clk);
        while (!req.ready);
        answer_q.push_back(table_predict(act, ln, col, kind, opn, eidx, cnt));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (answer_q.size() != 0)
            @(negedge clk);
        repeat (4 * TBL_DEPTH + 50) @(negedge clk);
    endtask

    // responses
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answer_q.size() == 0)
            begin
                $display("%0t: unexpected response status=%0d", $time, rsp.status);
                err_cnt++;
            end
            else
            begin
                e = answer_q.pop_front();
                if (rsp.status !== e.status || rsp.result_index !== e.idx ||
                    rsp.entry_line !== e.line || rsp.entry_col !== e.col ||
                    rsp.entry_kind !== e.kind || rsp.entry_open !== e.open ||
                    rsp.total_entries !== e.total)
                begin
                    $display("%0t: mismatch exp st=%0d idx=%0d ln=%0d col=%0d k=%0d o=%0d n=%0d",
                             $time, e.status, e.idx, e.line, e.col, e.kind, e.open, e.total);
                    $display("%0t:          act st=%0d idx=%0d ln=%0d col=%0d k=%0d o=%0d n=%0d",
                             $time, rsp.status, rsp.result_index, rsp.entry_line,
                             rsp.entry_col, rsp.entry_kind, rsp.entry_open, rsp.total_entries);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        int n;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
                rsp.ready <= 1'b0;
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n) @(negedge clk);
                rsp.ready <= 1'b1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    task automatic rand_request(int line_hi, int col_hi);
        int r;
        logic [sbt_pkg::ACT_W-1:0] act;
        r = $urandom_range(0, 99);
        if (r < 40)
            act = sbt_pkg::ACT_INSERT;
        else if (r < 55)
            act = sbt_pkg::ACT_LOOKUP;
        else if (r < 72)
            act = sbt_pkg::ACT_PARTNER;
        else if (r < 82)
            act = sbt_pkg::ACT_READ;
        else if (r < 88)
            act = sbt_pkg::ACT_CLEAR;
        else if (r < 93)
            act = sbt_pkg::ACT_ADD;
        else if (r < 98)
            act = sbt_pkg::ACT_REMOVE;
        else
            act = sbt_pkg::ACT_NONE;
        send_request(act, $urandom_range(0, line_hi), $urandom_range(0, col_hi),
                     $urandom_range(0, 3), $urandom_range(0, 1),
                     $urandom_range(0, table_cnt + 2),
                     ($urandom_range(0, 15) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                  : $urandom_range(0, 4));
    endtask

    task automatic test_directed();
        send_request(sbt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
        send_request(sbt_pkg::ACT_PARTNER, 0, 0, 0, 0, 0, 0);
        send_request(sbt_pkg::ACT_LOOKUP, 5, 5, 0, 0, 0, 0);
        send_request(sbt_pkg::ACT_INSERT, 10, 4, 1, 1, 0, 0);
        send_request(sbt_pkg::ACT_INSERT, 10, 9, 1, 0, 0, 0);
        send_request(sbt_pkg::ACT_INSERT, 20'hFFFFF, 16'hFFFF, 7'h7F, 1, 0, 0);
        send_request(sbt_pkg::ACT_INSERT, 0, 0, 0, 0, 0, 0);
        send_request(sbt_pkg::ACT_INSERT, 10, 6, 2, 1, 0, 0);
        send_request(sbt_pkg::ACT_LOOKUP, 10, 4, 0, 0, 0, 0);
        send_request(sbt_pkg::ACT_LOOKUP, 10, 5, 0, 0, 0, 0);
        send_request(sbt_pkg::ACT_LOOKUP, 10, 8, 0, 0, 0, 0);
        send_request(sbt_pkg::ACT_PARTNER, 0, 0, 0, 0, 1, 0);
        send_request(sbt_pkg::ACT_PARTNER, 0, 0, 0, 0, 3, 0);
        send_request(sbt_pkg::ACT_PARTNER, 0, 0, 0, 0, 4, 0);
        send_request(sbt_pkg::ACT_PARTNER, 0, 0, 0, 0, 2, 0);
        send_request(sbt_pkg::ACT_READ, 0, 0, 0, 0, 1023, 0);
        send_request(sbt_pkg::ACT_ADD, 5, 0, 0, 0, 0, 20'hFFFFF);
        send_request(sbt_pkg::ACT_READ, 0, 0, 0, 0, 1, 0);
        send_request(sbt_pkg::ACT_REMOVE, 20'hFFFFF, 0, 0, 0, 0, 20'hFFFFF);
        send_request(sbt_pkg::ACT_REMOVE, 0, 0, 0, 0, 0, 1);
        send_request(sbt_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0);
        send_request(sbt_pkg::ACT_NONE, 20'hFFFFF, 16'hFFFF, 7'h7F, 1, 1023, 20'hFFFFF);
        send_request(sbt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
        wait_drained();
    endtask

    task automatic test_random_edits();
        repeat (600)
            rand_request(($urandom_range(0, 9) == 0) ? 20'hFFFFF : 40,
                         ($urandom_range(0, 9) == 0) ? 16'hFFFF : 30);
        wait_drained();
    endtask

    task automatic test_full_table();
        int n;
        // fill with stalled responses to back the block up
        hold_rsp = 1'b1;
        fork
            begin
                n = 0;
                while (n < 400)
                begin
                    @(negedge clk);
                    n++;
                end
                hold_rsp = 1'b0;
            end
        join_none
        while (table_cnt < TBL_DEPTH)
            send_request(sbt_pkg::ACT_INSERT, $urandom_range(0, 60), $urandom_range(0, 50),
                         $urandom_range(0, 1), $urandom_range(0, 1), 0, 0);
        send_request(sbt_pkg::ACT_INSERT, 3, 3, 0, 1, 0, 0);
        send_request(sbt_pkg::ACT_READ, 0, 0, 0, 0, 1023, 0);
        send_request(sbt_pkg::ACT_PARTNER, 0, 0, 0, 0, 0, 0);
        send_request(sbt_pkg::ACT_PARTNER, 0, 0, 0, 0, 1023, 0);
        send_request(sbt_pkg::ACT_LOOKUP, 30, 20, 0, 0, 0, 0);
        send_request(sbt_pkg::ACT_ADD, 0, 0, 0, 0, 0, 20'hFFFF0);
        send_request(sbt_pkg::ACT_REMOVE, 20'hFFF00, 0, 0, 0, 0, 20'hFFFFF);
        wait_drained();
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        repeat (250)
            rand_request(40, 30);
        wait_drained();
    endtask

    initial
    begin
        err_cnt   = 0;
        cycle_cnt = 0;
        table_cnt = 0;
        idle_on   = 1'b1;
        hold_rsp  = 1'b0;
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.action = '0;
        req.position_line = '0;
        req.position_col = '0;
        req.paren_kind = '0;
        req.is_open = 1'b0;
        req.entry_index = '0;
        req.line_count = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_edits();
        test_full_table();
        test_quiet_tail();
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
src/sbt_pkg.sv
src/sbt_if.sv
src/sbt_ctrl.sv
src/sbt_dp.sv
src/sorted_bracket_table.sv
verif/tb_sorted_bracket_table.sv
